### src/tpig_pkg.sv
// Shared constants, tables and types of the terrain patch index generator.
package tpig_pkg;

  localparam int PATCH_GRIDS = 16;
  localparam int STRIDE_W    = 5;
  localparam int STRIDE_NUM  = 1 << STRIDE_W;
  localparam int IDX_W       = 24;
  localparam int TOTAL_W     = 11;
  localparam int SEC_W       = 2;
  localparam int LEN_W       = $clog2(PATCH_GRIDS + 1);
  localparam int MV_W        = $clog2(PATCH_GRIDS * PATCH_GRIDS + 1);
  // local triangle index within a section
  localparam int TRI_W       = MV_W;

  localparam logic [SEC_W-1:0] SEC_MAIN  = 2'd0;
  localparam logic [SEC_W-1:0] SEC_NORTH = 2'd1;
  localparam logic [SEC_W-1:0] SEC_EAST  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_MAIN  = 4'b0010,
    PH_NORTH = 4'b0100,
    PH_EAST  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    SEAM_EQUAL  = 2'd0,
    SEAM_COARSE = 2'd1,
    SEAM_FINE   = 2'd2
  } seam_mode_e;

  typedef struct packed {
    seam_mode_e       mode;
    logic [LEN_W-1:0] len;
    logic             live;
  } seam_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len_main;
    logic               main_live;
    seam_t              north;
    seam_t              east;
    logic [TOTAL_W-1:0] total;
    logic [IDX_W-1:0]   base_off;
    logic [IDX_W-1:0]   north_off;
    logic [IDX_W-1:0]   east_off;
  } patch_t;

  typedef struct packed {
    logic stay_col;     // another triangle remains in this column
    logic next_col_ok;  // next column exists and holds a triangle
  } seam_adv_t;

  typedef logic [STRIDE_NUM-1:0][LEN_W-1:0] len_table_t;
  typedef logic [STRIDE_NUM-1:0][MV_W-1:0]  mv_table_t;

  // Grid length for a stride, counted at elaboration; a zero stride counts as one.
  function automatic int len_calc(int s);
    int n;
    n = 0;
    for (int k = 1; k <= PATCH_GRIDS; k++) begin
      if (k * s <= PATCH_GRIDS) n++;
    end
    return n;
  endfunction

  function automatic len_table_t build_len_table();
    len_table_t tbl;
    for (int s = 0; s < STRIDE_NUM; s++) begin
      tbl[s] = LEN_W'(len_calc((s == 0) ? 1 : s));
    end
    return tbl;
  endfunction

  function automatic mv_table_t build_mv_table();
    mv_table_t tbl;
    int        v;
    for (int s = 0; s < STRIDE_NUM; s++) begin
      v      = len_calc((s == 0) ? 1 : s);
      tbl[s] = (v >= 2) ? MV_W'(v * v) : '0;
    end
    return tbl;
  endfunction

  localparam len_table_t LEN_TABLE = build_len_table();
  localparam mv_table_t  MV_TABLE  = build_mv_table();

endpackage

### src/tpig_setup.sv
// Patch setup: derives lengths, seam modes, offsets and vertex total from a start item.
module tpig_setup (
  input  logic [tpig_pkg::STRIDE_W-1:0] render_stride_i,
  input  logic [tpig_pkg::STRIDE_W-1:0] north_stride_i,
  input  logic [tpig_pkg::STRIDE_W-1:0] east_stride_i,
  input  logic [tpig_pkg::IDX_W-1:0]    base_offset_i,
  output tpig_pkg::patch_t              patch_o
);
  import tpig_pkg::*;

  localparam int SV_W = LEN_W + 2;

  logic [STRIDE_W-1:0] r_eff, n_eff, e_eff;
  logic [MV_W-1:0]     main_verts;
  seam_t               north, east;
  logic [SV_W-1:0]     north_verts, east_verts;

  function automatic logic [STRIDE_W-1:0] eff_stride(logic [STRIDE_W-1:0] s);
    return (s == '0) ? STRIDE_W'(1) : s;
  endfunction

  function automatic seam_t seam_of(logic [STRIDE_W-1:0] r, logic [STRIDE_W-1:0] nb,
                                    logic [STRIDE_W-1:0] r_raw,
                                    logic [STRIDE_W-1:0] nb_raw);
    seam_t s;
    if (nb == r) begin
      s.mode = SEAM_EQUAL;
      s.len  = LEN_TABLE[r_raw];
    end else if (nb > r) begin
      s.mode = SEAM_COARSE;
      s.len  = LEN_TABLE[r_raw];
    end else begin
      s.mode = SEAM_FINE;
      s.len  = LEN_TABLE[nb_raw];
    end
    s.live = (s.len != '0);
    return s;
  endfunction

  function automatic logic [SV_W-1:0] seam_verts(seam_t s);
    logic [SV_W-1:0] l;
    l = SV_W'(s.len);
    return (s.mode == SEAM_EQUAL) ? (l + l + SV_W'(1)) : (l + (l >> 1) + SV_W'(1));
  endfunction

  always_comb begin
    r_eff       = eff_stride(render_stride_i);
    n_eff       = eff_stride(north_stride_i);
    e_eff       = eff_stride(east_stride_i);
    main_verts  = MV_TABLE[render_stride_i];
    north       = seam_of(r_eff, n_eff, render_stride_i, north_stride_i);
    east        = seam_of(r_eff, e_eff, render_stride_i, east_stride_i);
    north_verts = seam_verts(north);
    east_verts  = seam_verts(east);

    patch_o.len_main  = LEN_TABLE[render_stride_i];
    patch_o.main_live = (LEN_TABLE[render_stride_i] >= LEN_W'(2));
    patch_o.north     = north;
    patch_o.east      = east;
    patch_o.total     = TOTAL_W'(IDX_W'(main_verts) + IDX_W'(north_verts)
                                 + IDX_W'(east_verts));
    patch_o.base_off  = base_offset_i;
    patch_o.north_off = base_offset_i + IDX_W'(main_verts);
    patch_o.east_off  = base_offset_i + IDX_W'(IDX_W'(main_verts) + IDX_W'(north_verts));
  end

endmodule

### src/tpig_seam_tri.sv
// Seam triangle: vertex indices and walk advance for one seam position.
module tpig_seam_tri (
  input  tpig_pkg::seam_t                seam_i,
  input  logic [tpig_pkg::LEN_W-1:0]     col_i,
  input  logic                           half_i,
  input  logic                           east_i,
  output logic [tpig_pkg::TRI_W-1:0]     t0_o,
  output logic [tpig_pkg::TRI_W-1:0]     t1_o,
  output logic [tpig_pkg::TRI_W-1:0]     t2_o,
  output tpig_pkg::seam_adv_t            adv_o
);
  import tpig_pkg::*;

  logic [TRI_W-1:0] i, l, h, ih, a1, a2;
  logic             odd;
  logic [1:0]       count;

  always_comb begin
    i   = TRI_W'(col_i);
    l   = TRI_W'(seam_i.len);
    h   = l >> 1;
    ih  = i >> 1;
    odd = col_i[0];
    t0_o  = i;
    a1    = i;
    a2    = i;
    count = 2'd1;
    case (seam_i.mode)
      SEAM_EQUAL: begin
        t0_o  = i;
        count = (i + TRI_W'(1) != l) ? 2'd2 : 2'd1;
        if (!half_i) begin
          a1 = l + i + TRI_W'(1);
          a2 = l + i;
        end else begin
          a1 = i + TRI_W'(1);
          a2 = l + i + TRI_W'(1);
        end
      end
      SEAM_COARSE: begin
        count = !odd ? 2'd2 : ((i + TRI_W'(1) < l) ? 2'd1 : 2'd0);
        if (odd) begin
          t0_o = i;
          a1   = i + TRI_W'(1);
          a2   = l + ih + TRI_W'(1);
        end else if (!half_i) begin
          t0_o = i;
          a1   = i + TRI_W'(1);
          a2   = l + ih;
        end else begin
          t0_o = i + TRI_W'(1);
          a1   = l + ih + TRI_W'(1);
          a2   = l + ih;
        end
      end
      default: begin
        t0_o  = h + i;
        count = !odd ? 2'd1 : ((i + TRI_W'(2) < l) ? 2'd2 : 2'd1);
        if (odd && (i + TRI_W'(2) < l)) begin
          if (!half_i) begin
            a1 = ih;
            a2 = ih + TRI_W'(1);
          end else begin
            a1 = ih + TRI_W'(1);
            a2 = h + i + TRI_W'(1);
          end
        end else begin
          a1 = ih;
          a2 = h + i + TRI_W'(1);
        end
      end
    endcase
    // east seam winds the other way
    t1_o = east_i ? a2 : a1;
    t2_o = east_i ? a1 : a2;

    adv_o.stay_col    = ({1'b0, half_i} + 2'd1) < count;
    // a coarse seam of even length drops its last column
    adv_o.next_col_ok = (i + TRI_W'(1) < l) &&
                        !((seam_i.mode == SEAM_COARSE) && !odd && (i + TRI_W'(2) >= l));
  end

endmodule

### src/terrain_patch_index_generator.sv
// Top level: triangle index walk over the main grid and both seams of a terrain patch.
//
// Input channel (in_valid_i / in_ready_o): op_i = 0 starts a patch and latches
// the three strides and base_offset_i; it produces no result. op_i = 1 steps
// the walk and produces one triangle, or nothing when no patch is active.
// Output channel (out_valid_o / out_ready_i): three vertex indices, the
// section, a last-triangle flag and the vertex total of the patch.
// out_valid_o rises in the cycle after acceptance; one item is taken per
// cycle unless the receiver stalls. The single result register behind the
// combinational index logic and the walk counters sets the rate.
// Input is taken while the result register is empty or drained in the same
// cycle; a stalled receiver holds the result and backs up the input.
// After reset the walk is idle and no result is pending; steps produce
// nothing until a start arrives. A start during a walk abandons it.
module terrain_patch_index_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [tpig_pkg::STRIDE_W-1:0]  render_stride_i,
  input  logic [tpig_pkg::STRIDE_W-1:0]  north_stride_i,
  input  logic [tpig_pkg::STRIDE_W-1:0]  east_stride_i,
  input  logic [tpig_pkg::IDX_W-1:0]     base_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tpig_pkg::IDX_W-1:0]     first_index_o,
  output logic [tpig_pkg::IDX_W-1:0]     second_index_o,
  output logic [tpig_pkg::IDX_W-1:0]     third_index_o,
  output logic [tpig_pkg::SEC_W-1:0]     section_o,
  output logic                           last_triangle_o,
  output logic [tpig_pkg::TOTAL_W-1:0]   total_vertices_o
);
  import tpig_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] row_q, row_d, col_q, col_d;
  logic             half_q, half_d;
  logic [TRI_W-1:0] cell_q, cell_d;
  patch_t           patch_q, patch_d, patch_new;
  logic             out_valid_q, out_valid_d;

  logic [IDX_W-1:0]   first_q, first_d, second_q, second_d, third_q, third_d;
  logic [SEC_W-1:0]   section_q, section_d;
  logic               last_q, last_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic             accept, emit;
  seam_t            seam_cur;
  logic [TRI_W-1:0] s_t0, s_t1, s_t2;
  seam_adv_t        s_adv;
  logic [TRI_W-1:0] t0, t1, t2, v_t, cell_b;
  logic [IDX_W-1:0] offset;
  logic             last_col, last_row;
  phase_e           after_main, after_north;

  tpig_setup u_setup (
    .render_stride_i (render_stride_i),
    .north_stride_i  (north_stride_i),
    .east_stride_i   (east_stride_i),
    .base_offset_i   (base_offset_i),
    .patch_o         (patch_new)
  );

  assign seam_cur = (phase_q == PH_EAST) ? patch_q.east : patch_q.north;

  tpig_seam_tri u_seam_tri (
    .seam_i (seam_cur),
    .col_i  (col_q),
    .half_i (half_q),
    .east_i (phase_q == PH_EAST),
    .t0_o   (s_t0),
    .t1_o   (s_t1),
    .t2_o   (s_t2),
    .adv_o  (s_adv)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && op_i && (phase_q != PH_IDLE);

  always_comb begin
    // cell_q is the top-left vertex of the current cell
    v_t      = TRI_W'(patch_q.len_main);
    cell_b   = cell_q + v_t;
    last_col = ((LEN_W + 1)'(col_q) + (LEN_W + 1)'(2)) == (LEN_W + 1)'(patch_q.len_main);
    last_row = ((LEN_W + 1)'(row_q) + (LEN_W + 1)'(2)) == (LEN_W + 1)'(patch_q.len_main);
    after_north = patch_q.east.live ? PH_EAST : PH_IDLE;
    after_main  = patch_q.north.live ? PH_NORTH : after_north;

    if (phase_q == PH_MAIN) begin
      t0 = cell_q;
      t1 = half_q ? (cell_q + TRI_W'(1)) : (cell_b + TRI_W'(1));
      t2 = half_q ? (cell_b + TRI_W'(1)) : cell_b;
    end else begin
      t0 = s_t0;
      t1 = s_t1;
      t2 = s_t2;
    end

    case (phase_q)
      PH_MAIN:  offset = patch_q.base_off;
      PH_NORTH: offset = patch_q.north_off;
      PH_EAST:  offset = patch_q.east_off;
      default:  offset = patch_q.base_off;
    endcase

    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    half_d  = half_q;
    cell_d  = cell_q;
    patch_d = patch_q;

    if (accept && !op_i) begin
      patch_d = patch_new;
      row_d   = '0;
      col_d   = '0;
      half_d  = 1'b0;
      cell_d  = '0;
      if (patch_new.main_live)       phase_d = PH_MAIN;
      else if (patch_new.north.live) phase_d = PH_NORTH;
      else if (patch_new.east.live)  phase_d = PH_EAST;
      else                           phase_d = PH_IDLE;
    end else if (emit) begin
      if (phase_q == PH_MAIN) begin
        if (!half_q) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (!last_col) begin
            col_d  = col_q + LEN_W'(1);
            cell_d = row_q[0] ? (cell_q - TRI_W'(1)) : (cell_q + TRI_W'(1));
          end else if (!last_row) begin
            col_d  = '0;
            row_d  = row_q + LEN_W'(1);
            cell_d = cell_b;
          end else begin
            col_d   = '0;
            row_d   = '0;
            phase_d = after_main;
          end
        end
      end else begin
        if (s_adv.stay_col) begin
          half_d = 1'b1;
        end else if (s_adv.next_col_ok) begin
          half_d = 1'b0;
          col_d  = col_q + LEN_W'(1);
        end else begin
          half_d  = 1'b0;
          col_d   = '0;
          phase_d = (phase_q == PH_NORTH) ? after_north : PH_IDLE;
        end
      end
    end

    // hold the result until the receiver takes it
    out_valid_d = out_valid_q && !out_ready_i;
    first_d     = first_q;
    second_d    = second_q;
    third_d     = third_q;
    section_d   = section_q;
    last_d      = last_q;
    total_d     = total_q;
    if (emit) begin
      out_valid_d = 1'b1;
      first_d     = offset + IDX_W'(t0);
      second_d    = offset + IDX_W'(t1);
      third_d     = offset + IDX_W'(t2);
      case (phase_q)
        PH_NORTH: section_d = SEC_NORTH;
        PH_EAST:  section_d = SEC_EAST;
        default:  section_d = SEC_MAIN;
      endcase
      last_d  = (phase_d == PH_IDLE);
      total_d = patch_q.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      half_q      <= 1'b0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      row_q       <= row_d;
      col_q       <= col_d;
      half_q      <= half_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    patch_q   <= patch_d;
    first_q   <= first_d;
    second_q  <= second_d;
    third_q   <= third_d;
    section_q <= section_d;
    last_q    <= last_d;
    total_q   <= total_d;
  end

  assign out_valid_o      = out_valid_q;
  assign first_index_o    = first_q;
  assign second_index_o   = second_q;
  assign third_index_o    = third_q;
  assign section_o        = section_q;
  assign last_triangle_o  = last_q;
  assign total_vertices_o = total_q;

endmodule

### verif/terrain_patch_index_generator_tb.sv
// Self-checking testbench of the terrain patch index generator: random patches, predicted triangles.
`timescale 1ns / 1ps

module terrain_patch_index_generator_tb;
  import tpig_pkg::*;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;
  localparam int   HALF_PERIOD   = 6;
  localparam int   TIMEOUT_NS    = 12 * 200000;
  localparam int   RANDOM_ITEMS  = 700;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   HOLD_AT_ITEM  = 200;
  localparam int   DRAIN_CYCLES  = 8;
  localparam int   PHASE_ITEMS   = 128;
  localparam int unsigned IDX_MASK = (1 << IDX_W) - 1;

  typedef struct packed {
    logic                op;
    logic [STRIDE_W-1:0] rs;
    logic [STRIDE_W-1:0] ns;
    logic [STRIDE_W-1:0] es;
    logic [IDX_W-1:0]    base;
  } patch_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   second;
    logic [IDX_W-1:0]   third;
    logic [SEC_W-1:0]   sec;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } triangle_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                op_i = OP_STEP;
  logic [STRIDE_W-1:0] render_stride_i = '0;
  logic [STRIDE_W-1:0] north_stride_i = '0;
  logic [STRIDE_W-1:0] east_stride_i = '0;
  logic [IDX_W-1:0]    base_offset_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IDX_W-1:0]    first_index_o;
  logic [IDX_W-1:0]    second_index_o;
  logic [IDX_W-1:0]    third_index_o;
  logic [SEC_W-1:0]    section_o;
  logic                last_triangle_o;
  logic [TOTAL_W-1:0]  total_vertices_o;

  terrain_patch_index_generator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .render_stride_i  (render_stride_i),
    .north_stride_i   (north_stride_i),
    .east_stride_i    (east_stride_i),
    .base_offset_i    (base_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_index_o    (first_index_o),
    .second_index_o   (second_index_o),
    .third_index_o    (third_index_o),
    .section_o        (section_o),
    .last_triangle_o  (last_triangle_o),
    .total_vertices_o (total_vertices_o)
  );

  patch_cmd_t  patch_cmds[$];
  triangle_t   want_tris[$];
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt = 0;
  logic        in_took = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // walk state of the predictor
  phase_e              walk_phase = PH_IDLE;
  int unsigned         walk_row = 0;
  int unsigned         walk_col = 0;
  int unsigned         walk_half = 0;
  logic [STRIDE_W-1:0] str_r = '0;
  logic [STRIDE_W-1:0] str_n = '0;
  logic [STRIDE_W-1:0] str_e = '0;
  int unsigned         sec_off = 0;

  function automatic int unsigned eff_stride(logic [STRIDE_W-1:0] s);
    return (s == 0) ? 1 : int'(s);
  endfunction

  function automatic int unsigned grid_len(int unsigned s);
    return PATCH_GRIDS / s;
  endfunction

  function automatic int unsigned main_verts(int unsigned r);
    int unsigned v;
    v = grid_len(r);
    return (v >= 2) ? v * v : 0;
  endfunction

  function automatic seam_mode_e seam_mode(int unsigned r, int unsigned nb);
    if (nb == r) return SEAM_EQUAL;
    return (nb > r) ? SEAM_COARSE : SEAM_FINE;
  endfunction

  function automatic int unsigned seam_len(int unsigned r, int unsigned nb);
    return (seam_mode(r, nb) == SEAM_FINE) ? grid_len(nb) : grid_len(r);
  endfunction

  function automatic int unsigned seam_verts(int unsigned r, int unsigned nb);
    int unsigned l;
    l = seam_len(r, nb);
    return (seam_mode(r, nb) == SEAM_EQUAL) ? 2 * l + 1 : l + l / 2 + 1;
  endfunction

  // triangles that seam column i holds
  function automatic int unsigned seam_count(seam_mode_e mode, int unsigned l, int unsigned i);
    bit odd;
    odd = i[0];
    if (mode == SEAM_EQUAL) return (i + 1 != l) ? 2 : 1;
    if (mode == SEAM_COARSE) return !odd ? 2 : ((i + 1 < l) ? 1 : 0);
    return !odd ? 1 : ((i + 2 < l) ? 2 : 1);
  endfunction

  function automatic void seam_tri(input seam_mode_e mode, input int unsigned l,
                                   input int unsigned i, input int unsigned half,
                                   input bit east, output int unsigned p0,
                                   output int unsigned p1, output int unsigned p2);
    int unsigned h, tmp;
    bit odd;
    h = l / 2;
    odd = i[0];
    if (mode == SEAM_EQUAL) begin
      p0 = i;
      if (half == 0) begin
        p1 = l + i + 1;
        p2 = l + i;
      end else begin
        p1 = i + 1;
        p2 = l + i + 1;
      end
    end else if (mode == SEAM_COARSE) begin
      if (odd) begin
        p0 = i; p1 = i + 1; p2 = l + i / 2 + 1;
      end else if (half == 0) begin
        p0 = i; p1 = i + 1; p2 = l + i / 2;
      end else begin
        p0 = i + 1; p1 = l + i / 2 + 1; p2 = l + i / 2;
      end
    end else begin
      p0 = h + i;
      if (odd && i + 2 < l) begin
        if (half == 0) begin
          p1 = i / 2; p2 = i / 2 + 1;
        end else begin
          p1 = i / 2 + 1; p2 = h + i + 1;
        end
      end else begin
        p1 = i / 2; p2 = h + i + 1;
      end
    end
    // east seam winds the other way
    if (east) begin
      tmp = p1; p1 = p2; p2 = tmp;
    end
  endfunction

  // move the walk onto the next triangle that exists, crossing sections
  function automatic void advance_walk();
    int unsigned r, v, nb, l;
    seam_mode_e mode;
    bit done;
    done = 1'b0;
    r = eff_stride(str_r);
    while (!done) begin
      case (walk_phase)
        PH_MAIN: begin
          v = grid_len(r);
          if (v >= 2 && walk_row < v - 1) begin
            if (walk_half >= 2) begin
              walk_half = 0;
              walk_col++;
            end
            if (walk_col < v - 1) begin
              done = 1'b1;
            end else begin
              walk_col = 0;
              walk_row++;
            end
          end else begin
            sec_off = (sec_off + main_verts(r)) & IDX_MASK;
            walk_phase = PH_NORTH;
            walk_row = 0; walk_col = 0; walk_half = 0;
          end
        end
        PH_NORTH, PH_EAST: begin
          nb = eff_stride((walk_phase == PH_NORTH) ? str_n : str_e);
          mode = seam_mode(r, nb);
          l = seam_len(r, nb);
          if (walk_col < l) begin
            if (walk_half < seam_count(mode, l, walk_col)) begin
              done = 1'b1;
            end else begin
              walk_col++;
              walk_half = 0;
            end
          end else begin
            sec_off = (sec_off + seam_verts(r, nb)) & IDX_MASK;
            walk_phase = (walk_phase == PH_NORTH) ? PH_EAST : PH_IDLE;
            walk_row = 0; walk_col = 0; walk_half = 0;
          end
        end
        default: begin
          walk_phase = PH_IDLE;
          done = 1'b1;
        end
      endcase
    end
  endfunction

  // apply one transaction to the walk; returns 1 when it emits a triangle
  function automatic bit predict_triangle(input patch_cmd_t c, output triangle_t t);
    int unsigned r, v, j, i, nb, l, total;
    int unsigned p0, p1, p2;
    t = '0;
    if (c.op == OP_START) begin
      str_r = c.rs;
      str_n = c.ns;
      str_e = c.es;
      sec_off = c.base;
      walk_phase = PH_MAIN;
      walk_row = 0; walk_col = 0; walk_half = 0;
      advance_walk();
      return 1'b0;
    end
    if (walk_phase == PH_IDLE) return 1'b0;
    r = eff_stride(str_r);
    if (walk_phase == PH_MAIN) begin
      v = grid_len(r);
      j = walk_row;
      if (j[0]) begin
        i = v - 1 - walk_col;
        p0 = (i - 1) + j * v;
        if (walk_half == 0) begin
          p1 = i + (j + 1) * v;
          p2 = (i - 1) + (j + 1) * v;
        end else begin
          p1 = i + j * v;
          p2 = i + (j + 1) * v;
        end
      end else begin
        i = walk_col;
        p0 = i + j * v;
        if (walk_half == 0) begin
          p1 = (i + 1) + (j + 1) * v;
          p2 = i + (j + 1) * v;
        end else begin
          p1 = (i + 1) + j * v;
          p2 = (i + 1) + (j + 1) * v;
        end
      end
      t.sec = SEC_MAIN;
    end else begin
      nb = eff_stride((walk_phase == PH_NORTH) ? str_n : str_e);
      l = seam_len(r, nb);
      seam_tri(seam_mode(r, nb), l, walk_col, walk_half, walk_phase == PH_EAST, p0, p1, p2);
      t.sec = (walk_phase == PH_NORTH) ? SEC_NORTH : SEC_EAST;
    end
    total = main_verts(r) + seam_verts(r, eff_stride(str_n)) + seam_verts(r, eff_stride(str_e));
    t.first  = IDX_W'(sec_off + p0);
    t.second = IDX_W'(sec_off + p1);
    t.third  = IDX_W'(sec_off + p2);
    t.total  = TOTAL_W'(total);
    walk_half++;
    advance_walk();
    t.last = (walk_phase == PH_IDLE);
    return 1'b1;
  endfunction

  task automatic push_cmd(logic op, logic [STRIDE_W-1:0] rs, logic [STRIDE_W-1:0] ns,
                          logic [STRIDE_W-1:0] es, logic [IDX_W-1:0] base);
    patch_cmd_t c;
    c.op = op; c.rs = rs; c.ns = ns; c.es = es; c.base = base;
    patch_cmds.push_back(c);
  endtask

  task automatic push_steps(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      push_cmd(OP_STEP, STRIDE_W'($urandom), STRIDE_W'($urandom), STRIDE_W'($urandom),
               IDX_W'($urandom));
    end
  endtask

  task automatic fill_stimulus();
    int unsigned random_cnt, big_left, tris, v, r, nb, l, sel, steps;
    logic [STRIDE_W-1:0] rs, ns, es;
    logic [IDX_W-1:0] base;
    seam_mode_e mode;
    big_left = 2;
    // step before any start, then a tiny patch that wraps the index space
    push_steps(1);
    push_cmd(OP_START, 5'd16, 5'd16, 5'd16, 24'hFFFFFF);
    push_steps(3);
    // strides past the grid: no triangles at all
    push_cmd(OP_START, 5'd31, 5'd31, 5'd20, 24'h000000);
    push_steps(1);
    // zero strides mean one; abandon this walk early
    push_cmd(OP_START, 5'd0, 5'd0, 5'd0, 24'h000000);
    push_steps(2);
    // coarser north, finer east
    push_cmd(OP_START, 5'd8, 5'd16, 5'd4, 24'h800000);
    push_steps(9);
    push_cmd(OP_START, 5'd8, 5'd8, 5'd16, 24'h7FFFFF);
    push_steps(2);

    random_cnt = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        // a full-size patch only early, so the item count stays near the target
        if ($urandom_range(15) == 0 && big_left > 0 && random_cnt < RANDOM_ITEMS / 4) begin
          r = 1;
          big_left--;
        end else begin
          r = 1 << $urandom_range(1, 4);
        end
        sel = $urandom_range(2);
        nb = (sel == 0) ? r >> 1 : (sel == 1) ? r : r << 1;
        if (nb == 0 || nb > PATCH_GRIDS) nb = r;
        rs = STRIDE_W'(r);
        ns = STRIDE_W'(nb);
        sel = $urandom_range(2);
        nb = (sel == 0) ? r >> 1 : (sel == 1) ? r : r << 1;
        if (nb == 0 || nb > PATCH_GRIDS) nb = r;
        es = STRIDE_W'(nb);
        v = grid_len(r);
        tris = (v >= 2) ? 2 * (v - 1) * (v - 1) : 0;
        for (int k = 0; k < 2; k++) begin
          nb = eff_stride((k == 0) ? ns : es);
          mode = seam_mode(r, nb);
          l = seam_len(r, nb);
          for (int unsigned i = 0; i < l; i++) tris += seam_count(mode, l, i);
        end
        steps = ($urandom_range(99) < 85) ? tris + $urandom_range(0, 2) : $urandom_range(0, tris);
      end else begin
        rs = STRIDE_W'($urandom);
        ns = STRIDE_W'($urandom);
        es = STRIDE_W'($urandom);
        steps = $urandom_range(0, 40);
      end
      base = ($urandom_range(7) == 0) ? IDX_W'(IDX_MASK - $urandom_range(0, 40))
                                      : IDX_W'($urandom);
      push_cmd(OP_START, rs, ns, es, base);
      push_steps(steps);
      random_cnt += steps + 1;
    end
  endtask

  initial begin
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // sender: offer the next transaction once the previous one is gone
  always @(negedge clk_i) begin
    int unsigned idle_pct;
    patch_cmd_t c;
    case ((accepted_cnt / PHASE_ITEMS) % 4)
      1:       idle_pct = 46;
      3:       idle_pct = 9;
      default: idle_pct = 0;
    endcase
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (patch_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        c = patch_cmds.pop_front();
        op_i <= c.op;
        render_stride_i <= c.rs;
        north_stride_i <= c.ns;
        east_stride_i <= c.es;
        base_offset_i <= c.base;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // one long receiver hold-off, so the result register fills and input backs up
  always @(negedge clk_i) begin
    if (!hold_done && accepted_cnt >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    int unsigned stall_pct;
    case ((accepted_cnt / PHASE_ITEMS) % 4)
      2:       stall_pct = 46;
      3:       stall_pct = 9;
      default: stall_pct = 0;
    endcase
    out_ready_i <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    patch_cmd_t c;
    triangle_t want, got;
    if (in_valid_i && in_ready_o) begin
      c.op = op_i;
      c.rs = render_stride_i;
      c.ns = north_stride_i;
      c.es = east_stride_i;
      c.base = base_offset_i;
      if (predict_triangle(c, want)) want_tris.push_back(want);
      accepted_cnt <= accepted_cnt + 1;
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
    if (out_valid_o && out_ready_i) begin
      got.first  = first_index_o;
      got.second = second_index_o;
      got.third  = third_index_o;
      got.sec    = section_o;
      got.last   = last_triangle_o;
      got.total  = total_vertices_o;
      if (want_tris.size() == 0) begin
        $display("%0t: unexpected triangle %h %h %h sec %0d last %0b total %0d", $time,
                 got.first, got.second, got.third, got.sec, got.last, got.total);
        error_cnt++;
      end else begin
        want = want_tris.pop_front();
        if (got !== want) begin
          $display("%0t: triangle mismatch", $time);
          $display("  expected %h %h %h sec %0d last %0b total %0d", want.first,
                   want.second, want.third, want.sec, want.last, want.total);
          $display("  actual   %h %h %h sec %0d last %0b total %0d", got.first,
                   got.second, got.third, got.sec, got.last, got.total);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    fill_stimulus();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (patch_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (want_tris.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && want_tris.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
